@@ sv/pva_pkg.sv @@
package pva_pkg;

  localparam int unsigned NumVoicesDef = 16;
  localparam int unsigned AgeBitsDef   = 32;
  localparam int unsigned MaxResults   = 16;
  localparam int unsigned ResCntW      = $clog2(MaxResults + 1);

  localparam int unsigned KeyW    = 7;
  localparam int unsigned VelW    = 7;
  localparam int unsigned IdxOutW = 4;
  localparam int unsigned ShiftW  = 3;

  localparam logic [3:0]      NibNoteOn  = 4'h9;
  localparam logic [3:0]      NibNoteOff = 4'h8;
  localparam logic [KeyW-1:0] NoteMax    = 7'd127;

  localparam logic RegOctaveShift = 1'b0;

  typedef enum logic [1:0] {
    StIdle   = 2'b01,
    StSearch = 2'b10
  } state_e;

endpackage

@@ sv/pva_cell.sv @@
module pva_cell #(
  parameter int unsigned NumVoices = pva_pkg::NumVoicesDef,
  parameter int unsigned AgeBits   = pva_pkg::AgeBitsDef,
  parameter int unsigned Idx       = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [pva_pkg::KeyW-1:0]  key_i,
  input  logic                      all_off_i,
  input  logic [$clog2(NumVoices)-1:0] from_i,
  input  logic                      set_i,
  input  logic                      clr_i,
  input  logic [$clog2(NumVoices)-1:0] wr_idx_i,
  input  logic [AgeBits-1:0]        wr_age_i,
  input  logic                      h1_f_i,
  input  logic [$clog2(NumVoices)-1:0] h1_idx_i,
  input  logic [pva_pkg::KeyW-1:0]  h1_key_i,
  input  logic                      h2_f_i,
  input  logic                      fr_f_i,
  input  logic [$clog2(NumVoices)-1:0] fr_idx_i,
  input  logic                      mn_f_i,
  input  logic [AgeBits-1:0]        mn_age_i,
  input  logic [$clog2(NumVoices)-1:0] mn_idx_i,
  output logic                      h1_f_o,
  output logic [$clog2(NumVoices)-1:0] h1_idx_o,
  output logic [pva_pkg::KeyW-1:0]  h1_key_o,
  output logic                      h2_f_o,
  output logic                      fr_f_o,
  output logic [$clog2(NumVoices)-1:0] fr_idx_o,
  output logic                      mn_f_o,
  output logic [AgeBits-1:0]        mn_age_o,
  output logic [$clog2(NumVoices)-1:0] mn_idx_o
);

  localparam int unsigned IdxW = $clog2(NumVoices);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic                     busy_q;
  logic [pva_pkg::KeyW-1:0] key_q;
  logic [AgeBits-1:0]       age_q;
  logic                     wr_sel;
  logic                     hit;

  logic                     h1_f_d, h2_f_d, fr_f_d, mn_f_d;
  logic [IdxW-1:0]          h1_idx_d, fr_idx_d, mn_idx_d;
  logic [pva_pkg::KeyW-1:0] h1_key_d;
  logic [AgeBits-1:0]       mn_age_d;

  assign wr_sel = (wr_idx_i == MyIdx);
  assign hit    = busy_q && (all_off_i || key_q == key_i) && (MyIdx >= from_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      key_q  <= '0;
      age_q  <= '0;
    end else if (wr_sel && set_i) begin
      busy_q <= 1'b1;
      key_q  <= key_i;
      age_q  <= wr_age_i;
    end else if (wr_sel && clr_i) begin
      busy_q <= 1'b0;
    end
  end

  always_comb begin
    h1_f_d   = h1_f_i;
    h1_idx_d = h1_idx_i;
    h1_key_d = h1_key_i;
    h2_f_d   = h2_f_i;
    if (h1_f_i) begin
      h2_f_d = h2_f_i || hit;
    end else if (hit) begin
      h1_f_d   = 1'b1;
      h1_idx_d = MyIdx;
      h1_key_d = key_q;
    end

    fr_f_d   = fr_f_i;
    fr_idx_d = fr_idx_i;
    if (!fr_f_i && !busy_q) begin
      fr_f_d   = 1'b1;
      fr_idx_d = MyIdx;
    end

    mn_f_d   = 1'b1;
    mn_age_d = mn_age_i;
    mn_idx_d = mn_idx_i;
    if (!mn_f_i || age_q < mn_age_i) begin
      mn_age_d = age_q;
      mn_idx_d = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_f_o <= 1'b0;
      h2_f_o <= 1'b0;
      fr_f_o <= 1'b0;
      mn_f_o <= 1'b0;
    end else begin
      h1_f_o <= h1_f_d;
      h2_f_o <= h2_f_d;
      fr_f_o <= fr_f_d;
      mn_f_o <= mn_f_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_idx_o <= h1_idx_d;
    h1_key_o <= h1_key_d;
    fr_idx_o <= fr_idx_d;
    mn_age_o <= mn_age_d;
    mn_idx_o <= mn_idx_d;
  end

endmodule

@@ sv/poly_voice_allocator_lru_unit.sv @@
// Polyphonic voice allocator with least-recently-started stealing.
// Input: an item is taken at a rising edge with start high and busy low
// (op_i, status_byte_i, note_number_i, key_velocity_i). Note-on reuses the
// voice holding the note, else the lowest free voice, else the oldest one.
// Note-off (or note-on at velocity zero) releases matching voices; op_i=1
// releases every busy voice. Other statuses are dropped; busy stays low.
// Results: one-cycle strobe result_valid_o with the voice fields; last_o
// flags the final result of an item. The receiver cannot stall.
// Search: each voice is a cell in a chain; a search wave walks the chain one
// cell per cycle while busy is high. A result is registered once the wave has
// passed the last cell. A note-on, or a release finding no voice, takes a
// single wave; a release that matched more voices starts a new wave from the
// voice after the one just released, one result per wave. The final result
// strobes in the first cycle with busy low, when the next item may already be
// taken.
// Config: APB, octave_shift at byte address 0; pready always high.
// Reset: all voices free, age counter and octave_shift zero.
module poly_voice_allocator_lru_unit #(
  parameter int unsigned NumVoices = pva_pkg::NumVoicesDef,
  parameter int unsigned AgeBits   = pva_pkg::AgeBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [7:0]                  status_byte_i,
  input  logic [pva_pkg::KeyW-1:0]    note_number_i,
  input  logic [pva_pkg::VelW-1:0]    key_velocity_i,
  output logic                        result_valid_o,
  output logic [pva_pkg::IdxOutW-1:0] voice_index_o,
  output logic [pva_pkg::KeyW-1:0]    voice_note_o,
  output logic                        gate_o,
  output logic [pva_pkg::VelW-1:0]    out_velocity_o,
  output logic                        last_o
);

  localparam int unsigned IdxW  = $clog2(NumVoices);
  localparam int unsigned WaveW = $clog2(NumVoices + 1);
  localparam int unsigned KeyW  = pva_pkg::KeyW;
  localparam int unsigned VelW  = pva_pkg::VelW;
  localparam int unsigned ResW  = pva_pkg::ResCntW;

  pva_pkg::state_e state_q, state_d;

  logic [WaveW-1:0]                 wave_q, wave_d;
  logic [KeyW-1:0]                  key_q, key_d;
  logic [VelW-1:0]                  vel_q, vel_d;
  logic                             on_q, on_d;
  logic                             all_off_q, all_off_d;
  logic [IdxW-1:0]                  from_q, from_d;
  logic [ResW-1:0]                  nres_q, nres_d;
  logic [AgeBits-1:0]               age_q, age_d;
  logic signed [pva_pkg::ShiftW-1:0] shift_q;

  logic                             rv_q, rv_d;
  logic [pva_pkg::IdxOutW-1:0]      ridx_q, ridx_d;
  logic [KeyW-1:0]                  rnote_q, rnote_d;
  logic                             rgate_q, rgate_d;
  logic [VelW-1:0]                  rvel_q, rvel_d;
  logic                             rlast_q, rlast_d;

  logic                             accept;
  logic [3:0]                       nib;
  logic                             is_on, is_rel;
  logic signed [8:0]                sx, t9;
  logic [KeyW-1:0]                  t_clamp;
  logic                             set_w, clr_w;
  logic [IdxW-1:0]                  wr_idx, sel;
  logic                             rel_last;

  logic                             h1_f   [NumVoices+1];
  logic [IdxW-1:0]                  h1_idx [NumVoices+1];
  logic [KeyW-1:0]                  h1_key [NumVoices+1];
  logic                             h2_f   [NumVoices+1];
  logic                             fr_f   [NumVoices+1];
  logic [IdxW-1:0]                  fr_idx [NumVoices+1];
  logic                             mn_f   [NumVoices+1];
  logic [AgeBits-1:0]               mn_age [NumVoices+1];
  logic [IdxW-1:0]                  mn_idx [NumVoices+1];

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pva_pkg::RegOctaveShift)
                  ? {29'b0, shift_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == pva_pkg::RegOctaveShift) begin
      shift_q <= pwdata[2:0];
    end
  end

  // transpose: note + shift*12, clamped
  assign sx = {{6{shift_q[2]}}, shift_q};
  assign t9 = $signed({2'b00, note_number_i}) + (sx <<< 3) + (sx <<< 2);

  always_comb begin
    if (t9[8]) begin
      t_clamp = '0;
    end else if (t9 > $signed({2'b00, pva_pkg::NoteMax})) begin
      t_clamp = pva_pkg::NoteMax;
    end else begin
      t_clamp = t9[KeyW-1:0];
    end
  end

  assign busy   = (state_q == pva_pkg::StSearch);
  assign accept = start && !busy;
  assign nib    = status_byte_i[7:4];
  assign is_on  = !op_i && nib == pva_pkg::NibNoteOn && key_velocity_i != '0;
  assign is_rel = op_i || nib == pva_pkg::NibNoteOn || nib == pva_pkg::NibNoteOff;

  // voice chain
  assign h1_f[0]   = 1'b0;
  assign h1_idx[0] = '0;
  assign h1_key[0] = '0;
  assign h2_f[0]   = 1'b0;
  assign fr_f[0]   = 1'b0;
  assign fr_idx[0] = '0;
  assign mn_f[0]   = 1'b0;
  assign mn_age[0] = '0;
  assign mn_idx[0] = '0;

  for (genvar g = 0; g < NumVoices; g++) begin : g_cell
    pva_cell #(
      .NumVoices (NumVoices),
      .AgeBits   (AgeBits),
      .Idx       (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .key_i     (key_q),
      .all_off_i (all_off_q),
      .from_i    (from_q),
      .set_i     (set_w),
      .clr_i     (clr_w),
      .wr_idx_i  (wr_idx),
      .wr_age_i  (age_d),
      .h1_f_i    (h1_f[g]),
      .h1_idx_i  (h1_idx[g]),
      .h1_key_i  (h1_key[g]),
      .h2_f_i    (h2_f[g]),
      .fr_f_i    (fr_f[g]),
      .fr_idx_i  (fr_idx[g]),
      .mn_f_i    (mn_f[g]),
      .mn_age_i  (mn_age[g]),
      .mn_idx_i  (mn_idx[g]),
      .h1_f_o    (h1_f[g+1]),
      .h1_idx_o  (h1_idx[g+1]),
      .h1_key_o  (h1_key[g+1]),
      .h2_f_o    (h2_f[g+1]),
      .fr_f_o    (fr_f[g+1]),
      .fr_idx_o  (fr_idx[g+1]),
      .mn_f_o    (mn_f[g+1]),
      .mn_age_o  (mn_age[g+1]),
      .mn_idx_o  (mn_idx[g+1])
    );
  end

  assign sel = h1_f[NumVoices] ? h1_idx[NumVoices]
             : fr_f[NumVoices] ? fr_idx[NumVoices]
             : mn_idx[NumVoices];
  assign wr_idx   = on_q ? sel : h1_idx[NumVoices];
  assign rel_last = !h2_f[NumVoices] || nres_q == ResW'(pva_pkg::MaxResults - 1);

  always_comb begin
    state_d   = state_q;
    wave_d    = wave_q;
    key_d     = key_q;
    vel_d     = vel_q;
    on_d      = on_q;
    all_off_d = all_off_q;
    from_d    = from_q;
    nres_d    = nres_q;
    age_d     = age_q + AgeBits'(1);
    set_w     = 1'b0;
    clr_w     = 1'b0;
    rv_d      = 1'b0;
    ridx_d    = ridx_q;
    rnote_d   = rnote_q;
    rgate_d   = rgate_q;
    rvel_d    = rvel_q;
    rlast_d   = rlast_q;

    unique case (state_q)
      pva_pkg::StIdle: begin
        if (accept && (is_on || is_rel)) begin
          state_d   = pva_pkg::StSearch;
          wave_d    = WaveW'(NumVoices);
          key_d     = t_clamp;
          vel_d     = key_velocity_i;
          on_d      = is_on;
          all_off_d = op_i;
          from_d    = '0;
          nres_d    = '0;
        end
      end
      pva_pkg::StSearch: begin
        if (wave_q != '0) begin
          wave_d = wave_q - WaveW'(1);
        end else if (on_q) begin
          set_w   = 1'b1;
          rv_d    = 1'b1;
          ridx_d  = pva_pkg::IdxOutW'(sel);
          rnote_d = key_q;
          rgate_d = 1'b1;
          rvel_d  = vel_q;
          rlast_d = 1'b1;
          state_d = pva_pkg::StIdle;
        end else if (h1_f[NumVoices]) begin
          clr_w   = 1'b1;
          rv_d    = 1'b1;
          ridx_d  = pva_pkg::IdxOutW'(h1_idx[NumVoices]);
          rnote_d = h1_key[NumVoices];
          rgate_d = 1'b0;
          rvel_d  = '0;
          rlast_d = rel_last;
          nres_d  = nres_q + ResW'(1);
          if (rel_last) begin
            state_d = pva_pkg::StIdle;
          end else begin
            from_d = h1_idx[NumVoices] + IdxW'(1);
            wave_d = WaveW'(NumVoices);
          end
        end else begin
          state_d = pva_pkg::StIdle;
        end
      end
      default: state_d = pva_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pva_pkg::StIdle;
      wave_q  <= '0;
      nres_q  <= '0;
      age_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wave_q  <= wave_d;
      nres_q  <= nres_d;
      if (set_w) begin
        age_q <= age_d;
      end
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    vel_q     <= vel_d;
    on_q      <= on_d;
    all_off_q <= all_off_d;
    from_q    <= from_d;
    ridx_q    <= ridx_d;
    rnote_q   <= rnote_d;
    rgate_q   <= rgate_d;
    rvel_q    <= rvel_d;
    rlast_q   <= rlast_d;
  end

  assign result_valid_o = rv_q;
  assign voice_index_o  = ridx_q;
  assign voice_note_o   = rnote_q;
  assign gate_o         = rgate_q;
  assign out_velocity_o = rvel_q;
  assign last_o         = rlast_q;

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("results on consecutive cycles");

  a_start_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && gate_o |-> last_o && out_velocity_o != '0)
    else $error("note start not a single item result with velocity");

  a_release_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !gate_o |-> out_velocity_o == '0)
    else $error("release with nonzero velocity");

  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("non-final result while idle");

endmodule

@@ tb/sv/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumVoices     = pva_pkg::NumVoicesDef;
  localparam int KeyW          = pva_pkg::KeyW;
  localparam int VelW          = pva_pkg::VelW;
  localparam int IdxOutW       = pva_pkg::IdxOutW;
  localparam int AgeW          = pva_pkg::AgeBitsDef;
  localparam int Semitones     = 12;
  localparam int WatchdogLimit = 4000;
  localparam int ItemsPerPhase = 55;
  localparam int NumPhases     = 7;
  localparam int QuietPause    = 40;

  localparam logic OpMidi   = 1'b0;
  localparam logic OpAllOff = 1'b1;
  localparam logic [3:0] NibOn     = pva_pkg::NibNoteOn;
  localparam logic [3:0] NibOff    = pva_pkg::NibNoteOff;
  localparam logic [3:0] NibCtrl   = 4'hB;
  localparam logic [3:0] NibSystem = 4'hF;
  localparam logic [3:0] NibNone   = 4'h0;

  localparam int ShiftSet [NumPhases] = '{0, 3, -3, 1, -1, 2, -2};

  typedef struct {
    logic            op;
    logic [7:0]      status;
    logic [KeyW-1:0] note;
    logic [VelW-1:0] vel;
  } midi_item_t;

  typedef struct {
    logic [IdxOutW-1:0] idx;
    logic [KeyW-1:0]    note;
    logic               gate;
    logic [VelW-1:0]    vel;
    logic               last;
  } voice_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic op_i = 1'b0;
  logic [7:0] status_byte_i = '0;
  logic [KeyW-1:0] note_number_i = '0;
  logic [VelW-1:0] key_velocity_i = '0;
  logic result_valid_o;
  logic [IdxOutW-1:0] voice_index_o;
  logic [KeyW-1:0] voice_note_o;
  logic gate_o;
  logic [VelW-1:0] out_velocity_o;
  logic last_o;

  midi_item_t   midi_item_q[$];
  voice_event_t voice_event_q[$];
  midi_item_t   cur_item;

  logic                held_q [NumVoices];
  logic [KeyW-1:0]     key_q  [NumVoices];
  logic [AgeW-1:0]     age_q  [NumVoices];
  logic [AgeW-1:0]     age_ctr;
  logic signed [pva_pkg::ShiftW-1:0] octave_q;

  int n_pushed = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_starts = 0;
  int n_releases = 0;
  int n_steals = 0;
  int n_fail = 0;
  int n_settings = 0;
  int gap_left = 0;
  int quiet_cycles = 0;
  bit tail_mode = 1'b0;

  poly_voice_allocator_lru_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .status_byte_i  (status_byte_i),
    .note_number_i  (note_number_i),
    .key_velocity_i (key_velocity_i),
    .result_valid_o (result_valid_o),
    .voice_index_o  (voice_index_o),
    .voice_note_o   (voice_note_o),
    .gate_o         (gate_o),
    .out_velocity_o (out_velocity_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic allocate_voices(input midi_item_t m);
    int i;
    int t;
    int sel;
    logic [KeyW-1:0] key;
    voice_event_t ev;
    voice_event_t evs[$];
    sel = -1;
    if (m.op == OpAllOff) begin
      for (i = 0; i < NumVoices && evs.size() < pva_pkg::MaxResults; i++) begin
        if (held_q[i]) begin
          held_q[i] = 1'b0;
          ev.idx = IdxOutW'(i);
          ev.note = key_q[i];
          ev.gate = 1'b0;
          ev.vel = '0;
          ev.last = 1'b0;
          evs.push_back(ev);
        end
      end
    end else begin
      t = int'(m.note) + Semitones * int'(octave_q);
      if (t < 0) t = 0;
      if (t > int'(pva_pkg::NoteMax)) t = int'(pva_pkg::NoteMax);
      key = KeyW'(t);
      if (m.status[7:4] == NibOn && m.vel != '0) begin
        for (i = 0; i < NumVoices; i++)
          if (sel < 0 && held_q[i] && key_q[i] == key) sel = i;
        for (i = 0; i < NumVoices; i++)
          if (sel < 0 && !held_q[i]) sel = i;
        if (sel < 0) begin
          sel = 0;
          for (i = 1; i < NumVoices; i++)
            if (age_q[i] < age_q[sel]) sel = i;
          n_steals++;
        end
        age_ctr = age_ctr + 1'b1;
        held_q[sel] = 1'b1;
        key_q[sel] = key;
        age_q[sel] = age_ctr;
        ev.idx = IdxOutW'(sel);
        ev.note = key;
        ev.gate = 1'b1;
        ev.vel = m.vel;
        ev.last = 1'b0;
        evs.push_back(ev);
      end else if (m.status[7:4] == NibOn || m.status[7:4] == NibOff) begin
        for (i = 0; i < NumVoices && evs.size() < pva_pkg::MaxResults; i++) begin
          if (held_q[i] && key_q[i] == key) begin
            held_q[i] = 1'b0;
            ev.idx = IdxOutW'(i);
            ev.note = key;
            ev.gate = 1'b0;
            ev.vel = '0;
            ev.last = 1'b0;
            evs.push_back(ev);
          end
        end
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[k]) begin
      voice_event_q.push_back(evs[k]);
      if (evs[k].gate) n_starts++;
      else n_releases++;
    end
  endtask

  task automatic push_item(input logic op, input logic [7:0] status,
                           input logic [KeyW-1:0] note, input logic [VelW-1:0] vel);
    midi_item_t m;
    m.op = op;
    m.status = status;
    m.note = note;
    m.vel = vel;
    midi_item_q.push_back(m);
    n_pushed++;
  endtask

  function automatic logic [KeyW-1:0] pick_note(input int pool_lo, input int pool_span);
    if ($urandom_range(0, 6) == 0) return KeyW'($urandom_range(0, 127));
    return KeyW'(pool_lo + $urandom_range(0, pool_span - 1));
  endfunction

  task automatic push_random_item(input int pool_lo, input int pool_span);
    int r;
    int nib;
    logic [3:0] chan;
    r = $urandom_range(0, 99);
    chan = 4'($urandom);
    if (r < 55) begin
      push_item(OpMidi, {NibOn, chan}, pick_note(pool_lo, pool_span),
                VelW'($urandom_range(1, 127)));
    end else if (r < 78) begin
      push_item(OpMidi, {NibOff, chan}, pick_note(pool_lo, pool_span),
                VelW'($urandom_range(0, 127)));
    end else if (r < 85) begin
      push_item(OpMidi, {NibOn, chan}, pick_note(pool_lo, pool_span), '0);
    end else if (r < 89) begin
      push_item(OpAllOff, 8'($urandom), KeyW'($urandom), VelW'($urandom));
    end else if (r < 96) begin
      nib = $urandom_range(0, 13);
      if (nib >= 8) nib += 2;
      push_item(OpMidi, {4'(nib), chan}, KeyW'($urandom), VelW'($urandom));
    end else begin
      push_item(OpMidi, 8'($urandom), KeyW'($urandom), VelW'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (n_accepted != n_pushed || voice_event_q.size() != 0 || busy)
      @(posedge clk_i);
    repeat (QuietPause) @(posedge clk_i);
  endtask

  task automatic write_octave_shift(input int shift);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * int'(pva_pkg::RegOctaveShift));
    pwdata <= 32'(shift);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    octave_q = pva_pkg::ShiftW'(shift);
    n_settings++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      op_i <= 1'b0;
      status_byte_i <= '0;
      note_number_i <= '0;
      key_velocity_i <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        allocate_voices(cur_item);
        n_accepted++;
      end
      if (start && busy) begin
      end else if (gap_left > 0) begin
        if (!busy) gap_left--;
        start <= 1'b0;
      end else if (midi_item_q.size() > 0) begin
        cur_item = midi_item_q.pop_front();
        op_i <= cur_item.op;
        status_byte_i <= cur_item.status;
        note_number_i <= cur_item.note;
        key_velocity_i <= cur_item.vel;
        start <= 1'b1;
        if (!tail_mode && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 8);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    voice_event_t exp_ev;
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (voice_event_q.size() == 0) begin
        $error("unexpected voice event: voice_index %0d voice_note %0d gate %0d",
               voice_index_o, voice_note_o, gate_o);
        n_fail++;
      end else begin
        exp_ev = voice_event_q.pop_front();
        if (voice_index_o !== exp_ev.idx) begin
          $error("voice_index: expected %0d, got %0d", exp_ev.idx, voice_index_o);
          n_fail++;
        end
        if (voice_note_o !== exp_ev.note) begin
          $error("voice_note: expected %0d, got %0d", exp_ev.note, voice_note_o);
          n_fail++;
        end
        if (gate_o !== exp_ev.gate) begin
          $error("gate: expected %0d, got %0d", exp_ev.gate, gate_o);
          n_fail++;
        end
        if (out_velocity_o !== exp_ev.vel) begin
          $error("out_velocity: expected %0d, got %0d", exp_ev.vel, out_velocity_o);
          n_fail++;
        end
        if (last_o !== exp_ev.last) begin
          $error("last: expected %0d, got %0d", exp_ev.last, last_o);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no activity for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int pool_lo;
    int pool_span;
    for (int i = 0; i < NumVoices; i++) begin
      held_q[i] = 1'b0;
      key_q[i] = '0;
      age_q[i] = '0;
    end
    age_ctr = '0;
    octave_q = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shift up: clamp at top, retrigger, releases, ignored statuses, all-off
    write_octave_shift(3);
    push_item(OpMidi, {NibOn, 4'hF}, 7'd127, 7'd127);
    push_item(OpMidi, {NibOn, 4'h0}, 7'd0, 7'd1);
    push_item(OpMidi, {NibOn, 4'h5}, 7'd127, 7'd64);
    push_item(OpMidi, {NibOff, 4'h0}, 7'd127, 7'd127);
    push_item(OpMidi, {NibOff, 4'hA}, 7'd127, 7'd0);
    push_item(OpMidi, {NibOn, 4'h3}, 7'd0, 7'd0);
    push_item(OpMidi, {NibCtrl, 4'h0}, 7'd60, 7'd100);
    push_item(OpMidi, {NibSystem, 4'hF}, 7'd127, 7'd127);
    push_item(OpMidi, {NibNone, 4'h0}, 7'd0, 7'd0);
    push_item(OpMidi, {NibOn, 4'h1}, 7'd60, 7'd100);
    push_item(OpMidi, {NibOn, 4'h2}, 7'd61, 7'd42);
    push_item(OpMidi, {NibOn, 4'h2}, 7'd85, 7'd127);
    push_item(OpAllOff, {NibOn, 4'h0}, 7'd60, 7'd127);
    push_item(OpAllOff, 8'hFF, 7'd127, 7'd127);
    wait_idle();

    // shift down: clamp at bottom, note-on at zero velocity as release
    write_octave_shift(-3);
    push_item(OpMidi, {NibOn, 4'h0}, 7'd0, 7'd127);
    push_item(OpMidi, {NibOn, 4'h7}, 7'd127, 7'd127);
    push_item(OpMidi, {NibOn, 4'h8}, 7'd20, 7'd9);
    push_item(OpMidi, {NibOff, 4'hF}, 7'd127, 7'd127);
    push_item(OpMidi, {NibOn, 4'hC}, 7'd35, 7'd0);
    push_item(OpMidi, {NibOff, 4'h0}, 7'd36, 7'd0);
    push_item(OpMidi, {NibOff, 4'h0}, 7'd40, 7'd0);
    push_item(OpAllOff, 8'h00, 7'd0, 7'd0);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      write_octave_shift(ShiftSet[p]);
      if (p == NumPhases - 1) tail_mode = 1'b1;
      pool_span = (p % 2 == 0) ? 20 : 28;
      pool_lo = $urandom_range(0, 128 - pool_span);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        push_random_item(pool_lo, pool_span);
        if (k % 8 == 7) pool_lo = $urandom_range(0, 128 - pool_span);
      end
      wait_idle();
    end

    $display("covered %0d items over %0d octave settings, %0d voice events",
             n_accepted, n_settings, n_results);
    $display("  %0d starts, %0d releases, %0d steals", n_starts, n_releases, n_steals);
    if (n_fail == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
